[hdl/assert_macros.svh]
// Assertion macros used by the checker file of the vector arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked assertion that also watches the reset cycles.
`define ASSERT_CLK_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hdl/vau_pkg.sv]
// Shared types, codes and helper functions of the vector arithmetic unit.
`default_nettype none

package vau_pkg;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_SCALE = 3'd2;
    localparam logic [2:0] OP_DIV   = 3'd3;
    localparam logic [2:0] OP_NEG   = 3'd4;
    localparam logic [2:0] OP_DOT   = 3'd5;
    localparam logic [2:0] OP_CROSS = 3'd6;
    localparam logic [2:0] OP_NORM  = 3'd7;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    typedef logic signed [31:0] fix_t;

    typedef struct packed {
        logic [2:0] op;
        fix_t [2:0] a;
        fix_t [2:0] b;
        fix_t       f;
    } item_t;

    // Product of one lane as sign and magnitude.
    typedef struct packed {
        logic [63:0] mag;
        logic        neg;
    } prod_t;

    // Everything an item carries alongside the square root and the dividers.
    typedef struct packed {
        logic [2:0]        op;
        logic [2:0][31:0]  r;
        logic [2:0]        lsat;
        logic [31:0]       sc;
        logic              dsat;
        logic [2:0]        aneg;
        logic [2:0][31:0]  amag;
        logic              fneg;
        logic [31:0]       fmag;
        logic              fzero;
    } side_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? 32'd0 - v : v;
    endfunction

    // Clamp a sign and magnitude value to 32 bits; the top bit flags saturation.
    function automatic logic [32:0] clamp32(input logic neg, input logic [63:0] mag);
        logic [32:0] res;
        if (neg) begin
            if (mag > 64'h0000_0000_8000_0000) begin
                res = {1'b1, 32'h8000_0000};
            end else begin
                res = {1'b0, 32'd0 - mag[31:0]};
            end
        end else begin
            if (mag > 64'h0000_0000_7FFF_FFFF) begin
                res = {1'b1, 32'h7FFF_FFFF};
            end else begin
                res = {1'b0, mag[31:0]};
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hdl/vector3_arithmetic_unit_top.sv]
// Throughput: one word per cycle; the pipeline only holds when a finished result waits
// at the output with another word right behind it.
// The length comes from a 32-stage square root, and each lane's quotient from a
// divider of 33 + FRAC_BITS stages, which together set the latency.
// Reset (aresetn low, synchronous) clears all valid bits and the output valid;
// data registers are not reset.
`default_nettype none

module vector3_arithmetic_unit_top #(
    parameter int FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, factor from bit 0 upward, 32 bits each.
    input  logic [223:0] s_tdata,
    // operation.
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // r_x, r_y, r_z, scalar_out (32 bits each), status (2 bits), then zero padding.
    output logic [135:0] m_tdata
);
    import vau_pkg::*;

    // Quotient width of the dividers and the width of their doubled divisor.
    localparam int NW = 33 + FRAC_BITS;
    localparam int DW = 34;
    // The side line is loaded from the lane and merge outputs; its tap at index 31
    // lines up with the square root result, its end with the quotients.
    localparam int SIDE_TAP = 31;
    localparam int SL = 33 + NW;
    localparam int KMAX = 36 + NW;

    logic            adv;
    logic [KMAX:0]   vld_reg;
    item_t           in_reg;
    item_t           d_reg [1:3];

    prod_t [2:0]      prods;
    logic [2:0][31:0] lane_r;
    logic [2:0]       lane_sat;
    logic [63:0]      sumsq;
    logic [31:0]      dot_sc;
    logic             dot_sat;
    logic [32:0]      len;

    side_t            side_next;
    side_t            side_reg [0:SL-1];
    side_t            tap;
    side_t            fin;
    logic             zf_next;
    logic             zd_reg [0:NW];
    logic [32:0]      dsel;
    logic [NW-1:0]    div_n [0:2];
    logic [DW-1:0]    div_d;
    logic [NW-1:0]    quot [0:2];

    logic [2:0][31:0] r_next;
    logic [31:0]      sc_next;
    logic [1:0]       status_next;
    logic             sat_any;
    logic [32:0]      cl [0:2];

    logic             m_tvalid_reg;
    logic [2:0][31:0] r_reg;
    logic [31:0]      sc_reg;
    logic [1:0]       status_reg;

    // The whole pipeline moves unless a finished word is stuck at the output
    // with another word right behind it.
    assign adv = !m_tvalid_reg || m_tready || !vld_reg[KMAX];
    assign s_tready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[KMAX-1:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_reg.op   <= s_tuser;
            in_reg.a[0] <= s_tdata[31:0];
            in_reg.a[1] <= s_tdata[63:32];
            in_reg.a[2] <= s_tdata[95:64];
            in_reg.b[0] <= s_tdata[127:96];
            in_reg.b[1] <= s_tdata[159:128];
            in_reg.b[2] <= s_tdata[191:160];
            in_reg.f    <= s_tdata[223:192];
            d_reg[1]    <= in_reg;
            d_reg[2]    <= d_reg[1];
            d_reg[3]    <= d_reg[2];
        end
    end

    // Three lanes, one per component. Lane k also owns the cross product
    // term a[k+1]*b[k+2] - a[k+2]*b[k+1].
    for (genvar k = 0; k < 3; k++) begin : g_lane
        localparam int IX = (k + 1) % 3;
        localparam int IY = (k + 2) % 3;
        vau_lane #(
            .FRAC_BITS(FRAC_BITS)
        ) u_lane (
            .aclk   (aclk),
            .en     (adv),
            .op     (in_reg.op),
            .a_self (in_reg.a[k]),
            .b_self (in_reg.b[k]),
            .f      (in_reg.f),
            .ca0    (in_reg.a[IX]),
            .cb0    (in_reg.b[IY]),
            .ca1    (in_reg.a[IY]),
            .cb1    (in_reg.b[IX]),
            .prod   (prods[k]),
            .r      (lane_r[k]),
            .sat    (lane_sat[k])
        );
    end

    vau_merge #(
        .FRAC_BITS(FRAC_BITS)
    ) u_merge (
        .aclk  (aclk),
        .en    (adv),
        .prods (prods),
        .sumsq (sumsq),
        .sc    (dot_sc),
        .dsat  (dot_sat)
    );

    vau_sqrt u_sqrt (
        .aclk (aclk),
        .en   (adv),
        .sq   (sumsq),
        .len  (len)
    );

    // Gather what the lanes and the merge stage found, alongside the item in d_reg[3].
    always_comb begin
        side_next.op    = d_reg[3].op;
        side_next.r     = lane_r;
        side_next.lsat  = lane_sat;
        side_next.sc    = dot_sc;
        side_next.dsat  = dot_sat;
        for (int k = 0; k < 3; k++) begin
            side_next.aneg[k] = d_reg[3].a[k][31];
            side_next.amag[k] = mag32(d_reg[3].a[k]);
        end
        side_next.fneg  = d_reg[3].f[31];
        side_next.fmag  = mag32(d_reg[3].f);
        side_next.fzero = (d_reg[3].f == 32'sd0);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= side_next;
            for (int i = 1; i < SL; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // Divider operands: quotient = (2 * (|a| << FRAC_BITS) + d) / (2 * d),
    // which is the division rounded to nearest with ties away from zero.
    assign tap = side_reg[SIDE_TAP];

    always_comb begin
        dsel = (tap.op == OP_NORM) ? len : {1'b0, tap.fmag};
        zf_next = (tap.op == OP_NORM) ? (len == 33'd0) : tap.fzero;
        div_d = {dsel, 1'b0};
        for (int k = 0; k < 3; k++) begin
            div_n[k] = {tap.amag[k], {(FRAC_BITS + 1){1'b0}}} + NW'(dsel);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            zd_reg[0] <= zf_next;
            for (int i = 1; i <= NW; i++) begin
                zd_reg[i] <= zd_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_div
        vau_div #(
            .NW(NW),
            .DW(DW)
        ) u_div (
            .aclk (aclk),
            .en   (adv),
            .n    (div_n[k]),
            .d    (div_d),
            .q    (quot[k])
        );
    end

    // Final selection by operation and status.
    assign fin = side_reg[SL-1];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            cl[k] = clamp32((fin.op == OP_NORM) ? fin.aneg[k] : (fin.aneg[k] ^ fin.fneg),
                            64'(quot[k]));
        end
        r_next = fin.r;
        sc_next = 32'd0;
        sat_any = |fin.lsat;
        case (fin.op)
            OP_DIV, OP_NORM: begin
                for (int k = 0; k < 3; k++) begin
                    r_next[k] = zd_reg[NW] ? 32'd0 : cl[k][31:0];
                end
                sat_any = !zd_reg[NW] && (cl[0][32] || cl[1][32] || cl[2][32]);
            end
            OP_DOT: begin
                r_next = '0;
                sc_next = fin.sc;
                sat_any = fin.dsat;
            end
            default: begin
                r_next = fin.r;
            end
        endcase
        if ((fin.op == OP_DIV || fin.op == OP_NORM) && zd_reg[NW]) begin
            status_next = ST_ZERO;
        end else if (sat_any) begin
            status_next = ST_SAT;
        end else begin
            status_next = ST_OK;
        end
    end

    // Output register: loads only when empty or when its word is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (!m_tvalid_reg || m_tready) begin
            m_tvalid_reg <= vld_reg[KMAX];
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_tvalid_reg || m_tready) begin
            r_reg      <= r_next;
            sc_reg     <= sc_next;
            status_reg <= status_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'd0, status_reg, sc_reg, r_reg[2], r_reg[1], r_reg[0]};

endmodule

`default_nettype wire

[hdl/vau_lane.sv]
// One component lane: two multipliers, the add path, rounding and clamping.
`default_nettype none

module vau_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [2:0]     op,
    input  logic [31:0]    a_self,
    input  logic [31:0]    b_self,
    input  logic [31:0]    f,
    input  logic [31:0]    ca0,
    input  logic [31:0]    cb0,
    input  logic [31:0]    ca1,
    input  logic [31:0]    cb1,
    output vau_pkg::prod_t prod,
    output logic [31:0]    r,
    output logic           sat
);
    import vau_pkg::*;

    localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

    logic [31:0] x0, y0, x1, y1;
    logic [63:0] pm0_next, pm1_next;
    logic [32:0] sum_next;
    logic        pn1_next;

    logic [63:0] pm0_reg, pm1_reg;
    logic        pn0_reg, pn1_reg;
    logic [32:0] sum_reg, sum2_reg;
    logic [2:0]  op_reg, op2_reg;

    logic [65:0] t0, t1, v;
    logic [65:0] vmag;
    logic [63:0] ex_mag_reg;
    logic        ex_neg_reg;

    logic [64:0] rnd;
    logic [32:0] smag;
    logic [32:0] cl_next;
    logic [31:0] r_reg;
    logic        sat_reg;

    // Operand selection for the two multipliers.
    always_comb begin
        x0 = a_self;
        y0 = a_self;
        x1 = 32'd0;
        y1 = 32'd0;
        pn1_next = 1'b0;
        case (op)
            OP_SCALE: y0 = f;
            OP_DOT:   y0 = b_self;
            OP_CROSS: begin
                x0 = ca0;
                y0 = cb0;
                x1 = ca1;
                y1 = cb1;
                pn1_next = ~(ca1[31] ^ cb1[31]);
            end
            default: y0 = a_self;
        endcase
        case (op)
            OP_SUB:  sum_next = {a_self[31], a_self} - {b_self[31], b_self};
            OP_NEG:  sum_next = 33'd0 - {a_self[31], a_self};
            default: sum_next = {a_self[31], a_self} + {b_self[31], b_self};
        endcase
    end

    assign pm0_next = mag32(x0) * mag32(y0);
    assign pm1_next = mag32(x1) * mag32(y1);

    always_ff @(posedge aclk) begin
        if (en) begin
            pm0_reg <= pm0_next;
            pm1_reg <= pm1_next;
            pn0_reg <= x0[31] ^ y0[31];
            pn1_reg <= pn1_next;
            sum_reg <= sum_next;
            op_reg  <= op;
        end
    end

    assign prod.mag = pm0_reg;
    assign prod.neg = pn0_reg;

    // Exact signed combination of the two products.
    always_comb begin
        t0 = pn0_reg ? 66'd0 - {2'b00, pm0_reg} : {2'b00, pm0_reg};
        t1 = pn1_reg ? 66'd0 - {2'b00, pm1_reg} : {2'b00, pm1_reg};
        v = t0 + t1;
        vmag = v[65] ? 66'd0 - v : v;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ex_mag_reg <= vmag[63:0];
            ex_neg_reg <= v[65];
            sum2_reg   <= sum_reg;
            op2_reg    <= op_reg;
        end
    end

    // Round the products to nearest, ties away from zero; clamp the chosen result.
    always_comb begin
        rnd = ({1'b0, ex_mag_reg} + HALF) >> FRAC_BITS;
        smag = sum2_reg[32] ? 33'd0 - sum2_reg : sum2_reg;
        if (op2_reg inside {OP_ADD, OP_SUB, OP_NEG}) begin
            cl_next = clamp32(sum2_reg[32], {31'd0, smag});
        end else begin
            cl_next = clamp32(ex_neg_reg, rnd[63:0]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            r_reg   <= cl_next[31:0];
            sat_reg <= cl_next[32];
        end
    end

    assign r   = r_reg;
    assign sat = sat_reg;

endmodule

`default_nettype wire

[hdl/vau_merge.sv]
// Merge stage: dot product and sum of squares over the three lanes.
`default_nettype none

module vau_merge #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 aclk,
    input  logic                 en,
    input  vau_pkg::prod_t [2:0] prods,
    output logic [63:0]          sumsq,
    output logic [31:0]          sc,
    output logic                 dsat
);
    import vau_pkg::*;

    localparam logic [64:0] HALF = 65'd1 << (FRAC_BITS - 1);

    logic [65:0] dot_next;
    logic [65:0] sq_next;
    logic [65:0] dot_reg;
    logic [63:0] sumsq_reg;
    logic [65:0] dmag;
    logic [64:0] rnd;
    logic [32:0] cl_next;
    logic [31:0] sc_reg;
    logic        dsat_reg;

    always_comb begin
        dot_next = 66'd0;
        sq_next  = 66'd0;
        for (int k = 0; k < 3; k++) begin
            dot_next = prods[k].neg ? dot_next - {2'b00, prods[k].mag}
                                    : dot_next + {2'b00, prods[k].mag};
            sq_next = sq_next + {2'b00, prods[k].mag};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot_reg   <= dot_next;
            sumsq_reg <= sq_next[63:0];
        end
    end

    always_comb begin
        dmag = dot_reg[65] ? 66'd0 - dot_reg : dot_reg;
        rnd = ({1'b0, dmag[63:0]} + HALF) >> FRAC_BITS;
        cl_next = clamp32(dot_reg[65], rnd[63:0]);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sc_reg   <= cl_next[31:0];
            dsat_reg <= cl_next[32];
        end
    end

    assign sumsq = sumsq_reg;
    assign sc    = sc_reg;
    assign dsat  = dsat_reg;

endmodule

`default_nettype wire

[hdl/vau_sqrt.sv]
// Pipelined rounded integer square root of a 64-bit value, one result bit per stage.
`default_nettype none

module vau_sqrt (
    input  logic        aclk,
    input  logic        en,
    input  logic [63:0] sq,
    output logic [32:0] len
);
    localparam int STEPS = 32;

    logic [63:0] s_reg [0:STEPS-1];
    logic [63:0] q_reg [0:STEPS-1];
    logic [63:0] s_next [0:STEPS-1];
    logic [63:0] q_next [0:STEPS-1];
    logic [32:0] len_reg;

    function automatic logic [127:0] sq_step(input logic [63:0] s, input logic [63:0] q,
                                             input int pos);
        logic [64:0] bitv;
        logic [64:0] trial;
        logic [64:0] diff;
        logic [64:0] qn;
        bitv = 65'd1 << pos;
        trial = {1'b0, q} + bitv;
        diff = {1'b0, s} - trial;
        qn = {2'b00, q[63:1]} + bitv;
        if ({1'b0, s} >= trial) begin
            return {diff[63:0], qn[63:0]};
        end
        return {s, 1'b0, q[63:1]};
    endfunction

    always_comb begin
        {s_next[0], q_next[0]} = sq_step(sq, 64'd0, 62);
        for (int i = 1; i < STEPS; i++) begin
            {s_next[i], q_next[i]} = sq_step(s_reg[i-1], q_reg[i-1], 62 - 2 * i);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < STEPS; i++) begin
                s_reg[i] <= s_next[i];
                q_reg[i] <= q_next[i];
            end
            len_reg <= q_reg[STEPS-1][32:0] + {32'd0, s_reg[STEPS-1] > q_reg[STEPS-1]};
        end
    end

    assign len = len_reg;

endmodule

`default_nettype wire

[hdl/vau_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module vau_div #(
    parameter int NW = 49,
    parameter int DW = 34
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [NW-1:0] q
);
    logic [NW-1:0] n_reg;
    logic [DW-1:0] d_reg;
    logic [DW-1:0] r_reg  [0:NW-1];
    logic [NW-1:0] w_reg  [0:NW-1];
    logic [DW-1:0] dv_reg [0:NW-1];
    logic [DW-1:0] r_next [0:NW-1];
    logic [NW-1:0] w_next [0:NW-1];

    function automatic logic [DW+NW-1:0] div_step(input logic [DW-1:0] r,
                                                  input logic [NW-1:0] w,
                                                  input logic [DW-1:0] dv);
        logic [DW:0] trial;
        logic [DW:0] diff;
        trial = {r, w[NW-1]};
        diff = trial - {1'b0, dv};
        if (trial >= {1'b0, dv}) begin
            return {diff[DW-1:0], w[NW-2:0], 1'b1};
        end
        return {trial[DW-1:0], w[NW-2:0], 1'b0};
    endfunction

    always_comb begin
        {r_next[0], w_next[0]} = div_step({DW{1'b0}}, n_reg, d_reg);
        for (int k = 1; k < NW; k++) begin
            {r_next[k], w_next[k]} = div_step(r_reg[k-1], w_reg[k-1], dv_reg[k-1]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg <= n;
            d_reg <= d;
            for (int k = 0; k < NW; k++) begin
                r_reg[k] <= r_next[k];
                w_reg[k] <= w_next[k];
            end
            dv_reg[0] <= d_reg;
            for (int k = 1; k < NW; k++) begin
                dv_reg[k] <= dv_reg[k-1];
            end
        end
    end

    assign q = w_reg[NW-1];

endmodule

`default_nettype wire

[hdl/vau_checker.sv]
// Port-level checker for the vector arithmetic unit and its bind.
`default_nettype none

`include "assert_macros.svh"

module vau_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [135:0] m_tdata
);
    import vau_pkg::*;

    `ASSERT_CLK_NORST(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `ASSERT_CLK(a_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled word changed")
    `ASSERT_CLK(a_ready_idle, aclk, aresetn, !m_tvalid || m_tready |-> s_tready, "input stalled with free output")
    `ASSERT_CLK(a_status_code, aclk, aresetn, m_tvalid |-> m_tdata[129:128] != 2'd3, "undefined status")
    `ASSERT_CLK(a_zero_result, aclk, aresetn, m_tvalid && m_tdata[129:128] == ST_ZERO |-> m_tdata[127:0] == 128'd0, "zero status with nonzero data")

endmodule

bind vector3_arithmetic_unit_top vau_checker u_vau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
